### hw/rtl/tdsp_pkg.sv
// Shared constants, codes and the operation record for the descriptor size parser.
package tdsp_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int ADD_W  = 37;
  localparam int DIM_W  = 31;
  localparam int SIZE_W = 63;

  localparam logic [SIZE_W-1:0] MAX_BYTES = '1;

  // input item function codes
  localparam logic [1:0] FN_CHAR   = 2'd0;
  localparam logic [1:0] FN_DIM    = 2'd1;
  localparam logic [1:0] FN_FINISH = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // one queued operation for the accumulator
  typedef struct packed {
    logic             add_en;
    logic [ADD_W-1:0] add_val;
    logic             mul_en;
    logic [DIM_W-1:0] dim;
    logic             emit;
    logic             invalid;
    logic             zero_res;
  } op_t;

endpackage

### hw/rtl/type_descriptor_size_parser_top.sv
// Type descriptor size parser: top level joining parser, queue and accumulator.
//
// Input beats (in_valid/in_stall) carry a function code: a descriptor
// character, a dimension value, or a finish with no dimensions. Characters
// are parsed at one beat per cycle while in_stall is low; a final dimension
// or a finish produces one result beat (out_valid/out_stall) with the byte total
// and a status. cfg_long_bytes sets the size of I8/U8 codes; cfg_ready is always high.
// The user makes writes only while the block is idle; the block does not enforce this.
// A finish or an invalid descriptor reaches out_valid through the queue and the
// output register; a final dimension also passes the combine state BK_MUL2, and
// when it also closes the descriptor string the pending add and BK_MUL1 come first.
// Throughput: the parser takes one beat per cycle while in_stall is low. The
// accumulator handles a byte add in BK_POP and a dimension in BK_POP and BK_MUL2
// (with BK_MUL1 as well for a pending add), the two-step 63 x 31 saturating
// multiply; a 4-entry queue absorbs the difference and in_stall rises only when it fills.
// When out_stall holds a result, the accumulator keeps working on queued
// non-result operations and waits only at the next result.
// Reset (rst_n low, synchronous) clears the parse state, the queue and the
// output, and sets long_bytes to 8.
module type_descriptor_size_parser_top
  import tdsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_type_char,
  input  logic [DIM_W-1:0]  in_dim_value,
  input  logic              in_last_dim,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIZE_W-1:0] out_size_bytes,
  output logic [1:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_long_bytes
);

  logic q_push;
  op_t  q_wdata;
  logic q_pop;
  op_t  q_head;
  logic q_full;
  logic q_empty;

  tdsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_type_char   (in_type_char),
    .in_dim_value   (in_dim_value),
    .in_last_dim    (in_last_dim),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_long_bytes (cfg_long_bytes),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  tdsp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  tdsp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_size_bytes (out_size_bytes),
    .out_status     (out_status)
  );

endmodule

### hw/rtl/tdsp_front.sv
// Descriptor character parser: classifies beats and queues accumulator operations.
module tdsp_front
  import tdsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [7:0]       in_type_char,
  input  logic [DIM_W-1:0] in_dim_value,
  input  logic             in_last_dim,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_long_bytes,
  input  logic             q_full,
  output logic             q_push,
  output op_t              q_wdata
);

  typedef enum logic [5:0] {
    PH_CODE1   = 6'b000001,
    PH_CODE2   = 6'b000010,
    PH_SEP     = 6'b000100,
    PH_DIGITS  = 6'b001000,
    PH_AFTERBR = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [3:0] LONG_RESET = 4'd8;

  // bit 5: code known, bits 4:0: element size
  function automatic logic [5:0] code_size(input logic [7:0] a, input logic [7:0] b,
                                           input logic [3:0] lb);
    logic [5:0] r;
    r = '0;
    if ((a == CH_I || a == CH_U) && b == CH_4)      r = {1'b1, 5'd4};
    else if ((a == CH_I || a == CH_U) && b == CH_8) r = {1'b1, 1'b0, lb};
    else if (a == CH_R && b == CH_4)                r = {1'b1, 5'd4};
    else if (a == CH_R && b == CH_8)                r = {1'b1, 5'd8};
    else if (a == CH_X && b == CH_4)                r = {1'b1, 5'd8};
    else if (a == CH_X && b == CH_8)                r = {1'b1, 5'd16};
    else if ((a == CH_B || a == CH_C) && b == CH_1) r = {1'b1, 5'd1};
    return r;
  endfunction

  phase_t      phase_r, phase_nxt, ph_s;
  logic [7:0]  first_r, first_nxt, first_s;
  logic        start_r, start_nxt, start_s;
  logic [4:0]  esize_r, esize_nxt, esize_s;
  logic [31:0] bcount_r, bcount_nxt, bc_s;
  logic        mt_r, mt_nxt, mt_s;
  logic        inv_r, inv_nxt, inv_s;
  logic [3:0]  long_bytes_r, long_bytes_nxt;

  logic             accept;
  logic [7:0]       c;
  logic [5:0]       cs;
  logic [35:0]      bc_tmp;
  logic [ADD_W-1:0] br_prod;
  logic             add_en_s;
  logic [ADD_W-1:0] add_val_s;
  logic             do_clear;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  assign cs      = code_size(first_r, c, long_bytes_r);
  assign bc_tmp  = ({4'b0, bcount_r} << 3) + ({4'b0, bcount_r} << 1) + {32'b0, c[3:0]};
  assign br_prod = ADD_W'(esize_r) * ADD_W'(bcount_r);

  // one character step; a dimension beat feeds the end-of-string character
  always_comb begin
    c = (in_func == FN_DIM) ? CH_NUL : in_type_char;
    if (c >= CH_LA && c <= CH_LZ) c = c - CASE_GAP;
    ph_s      = phase_r;
    first_s   = first_r;
    start_s   = start_r;
    esize_s   = esize_r;
    bc_s      = bcount_r;
    mt_s      = mt_r;
    inv_s     = inv_r;
    add_en_s  = 1'b0;
    add_val_s = '0;
    unique case (phase_r)
      PH_CODE1: begin
        if (c == CH_NUL) begin
          ph_s = PH_DONE;
        end else begin
          first_s = c;
          ph_s    = PH_CODE2;
        end
      end
      PH_CODE2: begin
        if (first_r == CH_M && c == CH_T) begin
          if (start_r) begin
            mt_s    = 1'b1;
            esize_s = '0;
            ph_s    = PH_SEP;
          end else begin
            inv_s = 1'b1;
            ph_s  = PH_DONE;
          end
        end else if (!cs[5]) begin
          inv_s = 1'b1;
          ph_s  = PH_DONE;
        end else begin
          esize_s = cs[4:0];
          ph_s    = PH_SEP;
        end
        start_s = 1'b0;
      end
      PH_SEP: begin
        if (mt_r) begin
          if (c == CH_NUL) begin
            ph_s = PH_DONE;
          end else begin
            inv_s = 1'b1;
            ph_s  = PH_DONE;
          end
        end else if (c == CH_NUL) begin
          add_en_s  = 1'b1;
          add_val_s = ADD_W'(esize_r);
          ph_s      = PH_DONE;
        end else if (c == CH_LBR) begin
          bc_s = '0;
          ph_s = PH_DIGITS;
        end else if (c == CH_COMMA) begin
          add_en_s  = 1'b1;
          add_val_s = ADD_W'(esize_r);
          ph_s      = PH_CODE1;
        end else begin
          inv_s = 1'b1;
          ph_s  = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (c >= CH_0 && c <= CH_9) begin
          bc_s = (bc_tmp[35:32] != 4'b0) ? '1 : bc_tmp[31:0];
        end else if (c == CH_RBR) begin
          ph_s = PH_AFTERBR;
        end else begin
          inv_s = 1'b1;
          ph_s  = PH_DONE;
        end
      end
      PH_AFTERBR: begin
        add_en_s  = 1'b1;
        add_val_s = br_prod;
        if (c == CH_COMMA) begin
          ph_s = PH_CODE1;
        end else if (c == CH_NUL) begin
          ph_s = PH_DONE;
        end else begin
          first_s = c;
          ph_s    = PH_CODE2;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    start_nxt      = start_r;
    esize_nxt      = esize_r;
    bcount_nxt     = bcount_r;
    mt_nxt         = mt_r;
    inv_nxt        = inv_r;
    long_bytes_nxt = cfg_valid ? cfg_long_bytes : long_bytes_r;
    do_clear       = 1'b0;
    q_push         = 1'b0;
    q_wdata        = '0;
    if (accept) begin
      unique case (in_func)
        FN_CHAR, FN_DIM: begin
          phase_nxt  = ph_s;
          first_nxt  = first_s;
          start_nxt  = start_s;
          esize_nxt  = esize_s;
          bcount_nxt = bc_s;
          mt_nxt     = mt_s;
          inv_nxt    = inv_s;
          q_wdata.add_en  = add_en_s;
          q_wdata.add_val = add_val_s;
          q_wdata.invalid = inv_s;
          if (in_func == FN_DIM) begin
            q_push         = 1'b1;
            q_wdata.mul_en = 1'b1;
            q_wdata.dim    = in_dim_value;
            q_wdata.emit   = in_last_dim;
            do_clear       = in_last_dim;
          end else begin
            q_push = add_en_s;
          end
        end
        FN_FINISH: begin
          q_push           = 1'b1;
          q_wdata.emit     = 1'b1;
          q_wdata.zero_res = 1'b1;
          do_clear         = 1'b1;
        end
        FN_NONE: begin
        end
      endcase
    end
    if (do_clear) begin
      phase_nxt  = PH_CODE1;
      first_nxt  = '0;
      start_nxt  = 1'b1;
      esize_nxt  = '0;
      bcount_nxt = '0;
      mt_nxt     = 1'b0;
      inv_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CODE1;
      first_r      <= '0;
      start_r      <= 1'b1;
      esize_r      <= '0;
      bcount_r     <= '0;
      mt_r         <= 1'b0;
      inv_r        <= 1'b0;
      long_bytes_r <= LONG_RESET;
    end else begin
      phase_r      <= phase_nxt;
      first_r      <= first_nxt;
      start_r      <= start_nxt;
      esize_r      <= esize_nxt;
      bcount_r     <= bcount_nxt;
      mt_r         <= mt_nxt;
      inv_r        <= inv_nxt;
      long_bytes_r <= long_bytes_nxt;
    end
  end

endmodule

### hw/rtl/tdsp_fifo.sv
// Short operation queue between the parser and the accumulator.
module tdsp_fifo
  import tdsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  wdata,
  input  logic pop,
  output op_t  head,
  output logic full,
  output logic empty
);

  op_t               mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

### hw/rtl/tdsp_back.sv
// Saturating byte accumulator and dimension multiplier with the result register.
module tdsp_back
  import tdsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  op_t               q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIZE_W-1:0] out_size_bytes,
  output logic [1:0]        out_status
);

  typedef enum logic [2:0] {
    BK_POP  = 3'b001,
    BK_MUL1 = 3'b010,
    BK_MUL2 = 3'b100
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  logic [SIZE_W-1:0] running_r, running_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DIM_W-1:0]  dim_r, dim_nxt;
  logic              emit_r, emit_nxt;
  logic [62:0]       pl_r, pl_nxt;
  logic [61:0]       ph_r, ph_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SIZE_W-1:0] out_size_r, out_size_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              out_free;
  logic [63:0]       sum;
  logic [SIZE_W-1:0] add_res;
  logic              add_ovf;
  logic              mul_go;
  logic [DIM_W-1:0]  mul_dim;
  logic [62:0]       pl_c;
  logic [61:0]       ph_c;
  logic [93:0]       total;
  logic              mul_ovf;
  logic [SIZE_W-1:0] mul_res;

  assign out_free = !out_valid_r || !out_stall;
  // a result beat is only popped once the output slot is known to be free
  assign q_pop    = (state_r == BK_POP) && !q_empty && (!q_head.emit || out_free);

  assign sum     = {1'b0, running_r} + 64'(q_head.add_val);
  assign add_res = !q_head.add_en ? running_r : (sum[63] ? MAX_BYTES : sum[62:0]);
  assign add_ovf = ovf_r | (q_head.add_en & sum[63]);
  assign mul_go  = q_head.mul_en && !q_head.invalid;

  // 63 x 31 product as two partials of at most 32 x 31
  assign mul_dim = (state_r == BK_MUL1) ? dim_r : q_head.dim;
  assign pl_c    = running_r[31:0] * mul_dim;
  assign ph_c    = running_r[62:32] * mul_dim;
  assign total   = {ph_r, 32'b0} + {31'b0, pl_r};
  assign mul_ovf = |total[93:63];
  assign mul_res = mul_ovf ? MAX_BYTES : total[62:0];

  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    ovf_nxt        = ovf_r;
    dim_nxt        = dim_r;
    emit_nxt       = emit_r;
    pl_nxt         = pl_r;
    ph_nxt         = ph_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_size_nxt   = out_size_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      BK_POP: begin
        if (q_pop) begin
          if (mul_go && q_head.add_en) begin
            running_nxt = add_res;
            ovf_nxt     = add_ovf;
            dim_nxt     = q_head.dim;
            emit_nxt    = q_head.emit;
            state_nxt   = BK_MUL1;
          end else if (mul_go) begin
            pl_nxt    = pl_c;
            ph_nxt    = ph_c;
            emit_nxt  = q_head.emit;
            state_nxt = BK_MUL2;
          end else if (q_head.emit) begin
            out_valid_nxt = 1'b1;
            if (q_head.zero_res) begin
              out_size_nxt   = '0;
              out_status_nxt = ST_OK;
            end else if (q_head.invalid) begin
              out_size_nxt   = '0;
              out_status_nxt = ST_INVALID;
            end else begin
              out_size_nxt   = add_res;
              out_status_nxt = add_ovf ? ST_OVERFLOW : ST_OK;
            end
            running_nxt = '0;
            ovf_nxt     = 1'b0;
          end else begin
            running_nxt = add_res;
            ovf_nxt     = add_ovf;
          end
        end
      end
      BK_MUL1: begin
        pl_nxt    = pl_c;
        ph_nxt    = ph_c;
        state_nxt = BK_MUL2;
      end
      BK_MUL2: begin
        if (emit_r) begin
          out_valid_nxt  = 1'b1;
          out_size_nxt   = mul_res;
          out_status_nxt = (ovf_r | mul_ovf) ? ST_OVERFLOW : ST_OK;
          running_nxt    = '0;
          ovf_nxt        = 1'b0;
        end else begin
          running_nxt = mul_res;
          ovf_nxt     = ovf_r | mul_ovf;
        end
        state_nxt = BK_POP;
      end
      default: begin
        state_nxt = BK_POP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_POP;
      running_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dim_r        <= dim_nxt;
    emit_r       <= emit_nxt;
    pl_r         <= pl_nxt;
    ph_r         <= ph_nxt;
    out_size_r   <= out_size_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_size_bytes = out_size_r;
  assign out_status     = out_status_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_INVALID |-> out_size_r == '0)
    else $error("invalid result carries a size");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_INVALID ||
                     out_status_r == ST_OVERFLOW))
    else $error("unused status code on output");
  a_mul1_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_MUL1 |=> state_r == BK_MUL2)
    else $error("multiply did not move to combine step");
  a_mul2_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_MUL2 |=> state_r == BK_POP)
    else $error("combine step did not return to pop");

endmodule
